FILE: sv/mos_pkg.sv
// package: shared types, codes, microcode table and helpers of the motion order sequencer
package mos_pkg;

	// fixed field widths
	localparam int FUNC_W  = 3;
	localparam int DIST_W  = 32;
	localparam int ANGLE_W = 24;
	localparam int PREC_W  = 16;
	localparam int PEND_W  = 4;
	localparam int STAT_W  = 2;
	localparam int KIND_W  = 2;
	localparam int CFG_IDX_W = 1;

	localparam int DEF_QUEUE_DEPTH = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIST_PREC  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_PREC = 1'd1;

	localparam logic [PREC_W-1:0] DIST_PREC_RST  = 16'd16;
	localparam logic [PREC_W-1:0] ANGLE_PREC_RST = 16'd256;

	// input function codes
	localparam logic [FUNC_W-1:0] FN_TICK   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DIST   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_AABS   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_AREL   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_PAUSE  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_RESUME = 3'd5;
	localparam logic [FUNC_W-1:0] FN_FLUSH  = 3'd6;

	// order kinds
	localparam logic [KIND_W-1:0] KIND_DIST  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_AABS  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_AREL  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_PAUSE = 2'd3;

	// insert status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_DROPPED = 2'd1;
	localparam logic [STAT_W-1:0] ST_EVICTED = 2'd2;

	// one queue entry as stored in the order memory
	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [DIST_W-1:0]  target;
		logic signed [DIST_W-1:0]  sdist;
		logic signed [ANGLE_W-1:0] sangle;
		logic                      started;
	} entry_t;

	// one result item
	typedef struct packed {
		logic                      distance_ref_valid;
		logic signed [DIST_W-1:0]  distance_ref;
		logic                      angle_ref_valid;
		logic signed [ANGLE_W-1:0] angle_ref;
		logic                      queue_ended;
		logic                      is_paused;
		logic [STAT_W-1:0]         insert_status;
		logic [PEND_W-1:0]         pending_orders;
	} result_t;

	// microcode
	localparam int UA_W = 5;
	typedef logic [UA_W-1:0] uaddr_t;

	localparam uaddr_t UA_IDLE  = 5'd0;
	localparam uaddr_t UA_TICK0 = 5'd1;
	localparam uaddr_t UA_TICK1 = 5'd2;
	localparam uaddr_t UA_TICK2 = 5'd3;
	localparam uaddr_t UA_TICK3 = 5'd4;
	localparam uaddr_t UA_ADD0  = 5'd5;
	localparam uaddr_t UA_ADD1  = 5'd6;
	localparam uaddr_t UA_ADDF  = 5'd7;
	localparam uaddr_t UA_PAU0  = 5'd8;
	localparam uaddr_t UA_PAU1  = 5'd9;
	localparam uaddr_t UA_PAU2  = 5'd10;
	localparam uaddr_t UA_RES0  = 5'd11;
	localparam uaddr_t UA_RES1  = 5'd12;
	localparam uaddr_t UA_RES2  = 5'd13;
	localparam uaddr_t UA_FLUSH = 5'd14;
	localparam uaddr_t UA_FIN0  = 5'd15;
	localparam uaddr_t UA_FIN1  = 5'd16;

	// memory write selects
	localparam logic [1:0] WR_NONE   = 2'd0;
	localparam logic [1:0] WR_APPEND = 2'd1;
	localparam logic [1:0] WR_SNAP   = 2'd2;
	localparam logic [1:0] WR_PAUSE  = 2'd3;

	// datapath actions
	localparam logic [2:0] ACT_NONE     = 3'd0;
	localparam logic [2:0] ACT_TAIL_INC = 3'd1;
	localparam logic [2:0] ACT_HEAD_INC = 3'd2;
	localparam logic [2:0] ACT_INSERT   = 3'd3;
	localparam logic [2:0] ACT_FLUSH    = 3'd4;
	localparam logic [2:0] ACT_SUM      = 3'd5;
	localparam logic [2:0] ACT_DIFF     = 3'd6;
	localparam logic [2:0] ACT_DECIDE   = 3'd7;

	// jump conditions
	localparam logic [2:0] C_NEVER      = 3'd0;
	localparam logic [2:0] C_ALWAYS     = 3'd1;
	localparam logic [2:0] C_EMPTY      = 3'd2;
	localparam logic [2:0] C_FULL       = 3'd3;
	localparam logic [2:0] C_PAUSED     = 3'd4;
	localparam logic [2:0] C_NOT_PAUSED = 3'd5;
	localparam logic [2:0] C_DROP       = 3'd6;

	typedef struct packed {
		logic       rd;
		logic [1:0] wr;
		logic [2:0] act;
		logic [2:0] cond;
		uaddr_t     target;
		logic       emit;
	} uword_t;

	function automatic uword_t mk_uw(logic rd, logic [1:0] wr, logic [2:0] act,
			logic [2:0] cond, uaddr_t target, logic emit);
		uword_t w;
		w.rd = rd;
		w.wr = wr;
		w.act = act;
		w.cond = cond;
		w.target = target;
		w.emit = emit;
		return w;
	endfunction

	// control store: one word per step; the jump is taken when cond holds, else step + 1
	function automatic uword_t ucode(uaddr_t a);
		uword_t w;
		case (a)
			UA_TICK0: w = mk_uw(1'b1, WR_NONE,   ACT_NONE,     C_EMPTY,      UA_FIN0,  1'b0);
			UA_TICK1: w = mk_uw(1'b0, WR_SNAP,   ACT_SUM,      C_NEVER,      UA_IDLE,  1'b0);
			UA_TICK2: w = mk_uw(1'b0, WR_NONE,   ACT_DIFF,     C_NEVER,      UA_IDLE,  1'b0);
			UA_TICK3: w = mk_uw(1'b0, WR_NONE,   ACT_DECIDE,   C_ALWAYS,     UA_FIN0,  1'b0);
			UA_ADD0:  w = mk_uw(1'b0, WR_NONE,   ACT_NONE,     C_FULL,       UA_ADDF,  1'b0);
			UA_ADD1:  w = mk_uw(1'b0, WR_APPEND, ACT_TAIL_INC, C_ALWAYS,     UA_FIN0,  1'b0);
			UA_ADDF:  w = mk_uw(1'b0, WR_NONE,   ACT_NONE,     C_DROP,       UA_FIN0,  1'b0);
			UA_PAU0:  w = mk_uw(1'b1, WR_NONE,   ACT_NONE,     C_NEVER,      UA_IDLE,  1'b0);
			UA_PAU1:  w = mk_uw(1'b0, WR_NONE,   ACT_NONE,     C_PAUSED,     UA_TICK0, 1'b0);
			UA_PAU2:  w = mk_uw(1'b0, WR_PAUSE,  ACT_INSERT,   C_ALWAYS,     UA_TICK0, 1'b0);
			UA_RES0:  w = mk_uw(1'b1, WR_NONE,   ACT_NONE,     C_EMPTY,      UA_FIN0,  1'b0);
			UA_RES1:  w = mk_uw(1'b0, WR_NONE,   ACT_NONE,     C_NOT_PAUSED, UA_FIN0,  1'b0);
			UA_RES2:  w = mk_uw(1'b0, WR_NONE,   ACT_HEAD_INC, C_ALWAYS,     UA_RES0,  1'b0);
			UA_FLUSH: w = mk_uw(1'b0, WR_NONE,   ACT_FLUSH,    C_ALWAYS,     UA_FIN0,  1'b0);
			UA_FIN0:  w = mk_uw(1'b1, WR_NONE,   ACT_NONE,     C_NEVER,      UA_IDLE,  1'b0);
			UA_FIN1:  w = mk_uw(1'b0, WR_NONE,   ACT_NONE,     C_ALWAYS,     UA_IDLE,  1'b1);
			default:  w = mk_uw(1'b0, WR_NONE,   ACT_NONE,     C_NEVER,      UA_IDLE,  1'b0);
		endcase
		return w;
	endfunction

	// entry point of each function's program
	function automatic uaddr_t dispatch(logic [FUNC_W-1:0] f);
		uaddr_t a;
		case (f)
			FN_TICK:   a = UA_TICK0;
			FN_DIST:   a = UA_ADD0;
			FN_AABS:   a = UA_ADD0;
			FN_AREL:   a = UA_ADD0;
			FN_PAUSE:  a = UA_PAU0;
			FN_RESUME: a = UA_RES0;
			FN_FLUSH:  a = UA_FLUSH;
			default:   a = UA_FIN0;
		endcase
		return a;
	endfunction

endpackage

FILE: sv/mos_in_if.sv
// interface: order channel of the motion order sequencer
interface mos_in_if;
	logic                                      valid;
	logic                                      ready;
	logic [mos_pkg::FUNC_W-1:0]                func;
	logic signed [mos_pkg::DIST_W-1:0]         order_amount;
	logic signed [mos_pkg::DIST_W-1:0]         measured_distance;
	logic signed [mos_pkg::ANGLE_W-1:0]        measured_angle;

	modport source (output valid, func, order_amount, measured_distance, measured_angle,
		input ready);
	modport sink (input valid, func, order_amount, measured_distance, measured_angle,
		output ready);
endinterface

FILE: sv/mos_out_if.sv
// interface: reference channel of the motion order sequencer
interface mos_out_if;
	logic                                valid;
	logic                                ready;
	logic                                distance_ref_valid;
	logic signed [mos_pkg::DIST_W-1:0]   distance_ref;
	logic                                angle_ref_valid;
	logic signed [mos_pkg::ANGLE_W-1:0]  angle_ref;
	logic                                queue_ended;
	logic                                is_paused;
	logic [mos_pkg::STAT_W-1:0]          insert_status;
	logic [mos_pkg::PEND_W-1:0]          pending_orders;

	modport source (output valid, distance_ref_valid, distance_ref, angle_ref_valid, angle_ref,
		queue_ended, is_paused, insert_status, pending_orders, input ready);
	modport sink (input valid, distance_ref_valid, distance_ref, angle_ref_valid, angle_ref,
		queue_ended, is_paused, insert_status, pending_orders, output ready);
endinterface

FILE: sv/mos_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module mos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH)-1:0]       waddr,
	input  logic [WIDTH-1:0]               wdata,
	input  logic                           re,
	input  logic [$clog2(DEPTH)-1:0]       raddr,
	output logic [WIDTH-1:0]               rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: sv/motion_order_sequencer_unit.sv
// top level: microcoded motion order sequencer with its order queue
//
// channel   dir  handshake        payload
// orders    in   valid / ready    func, order_amount, measured_distance, measured_angle
// refs      out  valid / ready    references, queue status, insert status, pending count
// cfg       in   cfg_we only      cfg_index, cfg_data (precision registers)
//
// one item at a time; orders.ready is high whenever the sequencer sits at its idle step,
// also while a result still waits in the output register
// each function runs its own microcode program, with a registered read of the order
// memory, back to the idle step; a tick on an empty queue skips its arithmetic, a pause
// on a paused queue skips its insert, and a resume steps over each leading pause
// arst_n resets the step counter, head, tail, precision registers and output valid; the
// order memory is not cleared, entries between head and tail are always written ones
// a stalled refs channel holds the sequencer at its final step
module motion_order_sequencer_unit #(
	parameter int QUEUE_DEPTH = mos_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mos_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mos_pkg::PREC_W-1:0]      cfg_data,
	mos_in_if.sink                          orders,
	mos_out_if.source                       refs
);
	import mos_pkg::*;

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = (IW + 1 > PEND_W) ? IW + 1 : PEND_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
	localparam int EW = $bits(entry_t);

	// ring index helpers, depth need not be a power of two
	function automatic logic [IW-1:0] next_i(logic [IW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + IW'(1);
	endfunction

	function automatic logic [IW-1:0] prev_i(logic [IW-1:0] i);
		return (i == '0) ? LAST_IDX : i - IW'(1);
	endfunction

	// saturate a 33 bit sum into its field
	function automatic logic signed [DIST_W-1:0] sat_dist(logic signed [DIST_W:0] v);
		logic signed [DIST_W-1:0] r;
		if (v[DIST_W] != v[DIST_W-1]) begin
			r = v[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
		end else begin
			r = v[DIST_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [ANGLE_W-1:0] sat_angle(logic signed [DIST_W:0] v);
		logic signed [ANGLE_W-1:0] r;
		if (v[DIST_W:ANGLE_W-1] != {(DIST_W-ANGLE_W+2){v[DIST_W]}}) begin
			r = v[DIST_W] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
		end else begin
			r = v[ANGLE_W-1:0];
		end
		return r;
	endfunction

	// control
	uaddr_t  step_q;
	uword_t  uw;
	logic    in_fire;
	logic    cond_ok;
	logic    stall;

	// queue pointers and registers
	logic [IW-1:0]       head_q, tail_q;
	logic [PREC_W-1:0]   dprec_q, aprec_q;
	logic                empty, full, rd_paused;
	logic [CW-1:0]       pend_w;

	// latched item
	logic [KIND_W-1:0]          new_kind_q;
	logic signed [DIST_W-1:0]   amount_q;
	logic signed [DIST_W-1:0]   md_q;
	logic signed [ANGLE_W-1:0]  ma_q;

	// order memory ports
	logic            ram_we;
	logic [IW-1:0]   ram_waddr;
	entry_t          ram_wdata;
	entry_t          rd;
	logic [EW-1:0]   rd_bits;

	// tick datapath
	logic [KIND_W-1:0]          kind_q;
	logic signed [DIST_W-1:0]   sd_q;
	logic signed [ANGLE_W-1:0]  sa_q;
	logic signed [DIST_W:0]     ref_q;
	logic signed [DIST_W+1:0]   diff_q;
	logic signed [DIST_W-1:0]   sd_eff;
	logic signed [ANGLE_W-1:0]  sa_eff;
	logic [DIST_W+1:0]          mag;
	logic [PREC_W-1:0]          prec_sel;
	logic                       close_enough;

	// result staging and output register
	result_t  stage_q;
	result_t  stage_d;
	result_t  out_q;
	result_t  out_d;
	logic     ovalid_q;

	assign uw       = ucode(step_q);
	assign in_fire  = orders.valid && orders.ready;
	assign orders.ready = (step_q == UA_IDLE);

	assign empty     = (head_q == tail_q);
	assign full      = (next_i(tail_q) == head_q);
	assign rd        = entry_t'(rd_bits);
	assign rd_paused = !empty && (rd.kind == KIND_PAUSE);

	// pending count wraps at the depth, only the low bits are reported
	assign pend_w = (tail_q >= head_q) ?
		CW'(tail_q) - CW'(head_q) :
		CW'(tail_q) + CW'(QUEUE_DEPTH) - CW'(head_q);

	always_comb begin
		case (uw.cond)
			C_ALWAYS:     cond_ok = 1'b1;
			C_EMPTY:      cond_ok = empty;
			C_FULL:       cond_ok = full;
			C_PAUSED:     cond_ok = rd_paused;
			C_NOT_PAUSED: cond_ok = !rd_paused;
			C_DROP:       cond_ok = 1'b1;
			default:      cond_ok = 1'b0;
		endcase
	end

	// final step waits while the previous result has not been taken
	assign stall = uw.emit && ovalid_q && !refs.ready;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= UA_IDLE;
		end else if (step_q == UA_IDLE) begin
			if (in_fire) begin
				step_q <= dispatch(orders.func);
			end
		end else if (!stall) begin
			step_q <= cond_ok ? uw.target : step_q + uaddr_t'(1);
		end
	end

	// precision registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dprec_q <= DIST_PREC_RST;
			aprec_q <= ANGLE_PREC_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_DIST_PREC) begin
				dprec_q <= cfg_data;
			end
			if (cfg_index == REG_ANGLE_PREC) begin
				aprec_q <= cfg_data;
			end
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			new_kind_q <= KIND_W'(orders.func - FN_DIST);
			amount_q   <= orders.order_amount;
			md_q       <= orders.measured_distance;
			ma_q       <= orders.measured_angle;
		end
	end

	// snapshot on first use of an order
	assign sd_eff = rd.started ? rd.sdist  : md_q;
	assign sa_eff = rd.started ? rd.sangle : ma_q;

	// memory write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = rd;
		case (uw.wr)
			WR_APPEND: begin
				ram_we            = 1'b1;
				ram_waddr         = tail_q;
				ram_wdata.kind    = new_kind_q;
				ram_wdata.target  = amount_q;
				ram_wdata.sdist   = '0;
				ram_wdata.sangle  = '0;
				ram_wdata.started = 1'b0;
			end
			WR_SNAP: begin
				ram_we            = !rd.started;
				ram_waddr         = head_q;
				ram_wdata.sdist   = md_q;
				ram_wdata.sangle  = ma_q;
				ram_wdata.started = 1'b1;
			end
			WR_PAUSE: begin
				ram_we            = 1'b1;
				ram_waddr         = prev_i(head_q);
				ram_wdata.kind    = KIND_PAUSE;
				ram_wdata.target  = '0;
				ram_wdata.sdist   = '0;
				ram_wdata.sangle  = '0;
				ram_wdata.started = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	mos_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_order_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (uw.rd),
		.raddr (head_q),
		.rdata (rd_bits)
	);

	// completion test on the exact error
	assign mag          = diff_q[DIST_W+1] ? (DIST_W+2)'(0) - diff_q : diff_q;
	assign prec_sel     = (kind_q == KIND_DIST) ? dprec_q : aprec_q;
	assign close_enough = (mag < {{(DIST_W+2-PREC_W){1'b0}}, prec_sel});

	// tick arithmetic: sum, then difference, then decision
	always_ff @(posedge clk) begin
		case (uw.act)
			ACT_SUM: begin
				kind_q <= rd.kind;
				sd_q   <= sd_eff;
				sa_q   <= sa_eff;
				case (rd.kind)
					KIND_DIST: ref_q <= {sd_eff[DIST_W-1], sd_eff} +
						{rd.target[DIST_W-1], rd.target};
					KIND_AABS: ref_q <= {rd.target[DIST_W-1], rd.target};
					KIND_AREL: ref_q <= {{(DIST_W-ANGLE_W+1){sa_eff[ANGLE_W-1]}}, sa_eff} +
						{rd.target[DIST_W-1], rd.target};
					default:   ref_q <= '0;
				endcase
			end
			ACT_DIFF: begin
				if (kind_q == KIND_DIST) begin
					diff_q <= {ref_q[DIST_W], ref_q} - {{2{md_q[DIST_W-1]}}, md_q};
				end else begin
					diff_q <= {ref_q[DIST_W], ref_q} -
						{{(DIST_W-ANGLE_W+2){ma_q[ANGLE_W-1]}}, ma_q};
				end
			end
			default: begin
			end
		endcase
	end

	// head and tail pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			case (uw.act)
				ACT_TAIL_INC: tail_q <= next_i(tail_q);
				ACT_HEAD_INC: head_q <= next_i(head_q);
				ACT_INSERT: begin
					// a full queue loses its newest order to make room
					if (full) begin
						tail_q <= prev_i(tail_q);
					end
					head_q <= prev_i(head_q);
				end
				ACT_FLUSH:  head_q <= tail_q;
				ACT_DECIDE: begin
					if (kind_q != KIND_PAUSE && close_enough) begin
						head_q <= next_i(head_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// next staged result from the current step
	always_comb begin
		stage_d = stage_q;
		if (uw.cond == C_DROP) begin
			stage_d.insert_status = ST_DROPPED;
		end
		if (uw.act == ACT_INSERT && full) begin
			stage_d.insert_status = ST_EVICTED;
		end
		if (uw.act == ACT_DECIDE) begin
			if (kind_q == KIND_PAUSE) begin
				// a pause holds position on both loops
				stage_d.distance_ref_valid = 1'b1;
				stage_d.distance_ref       = sd_q;
				stage_d.angle_ref_valid    = 1'b1;
				stage_d.angle_ref          = sa_q;
			end else if (!close_enough) begin
				if (kind_q == KIND_DIST) begin
					stage_d.distance_ref_valid = 1'b1;
					stage_d.distance_ref       = sat_dist(ref_q);
				end else begin
					stage_d.angle_ref_valid = 1'b1;
					stage_d.angle_ref       = sat_angle(ref_q);
				end
			end
		end
	end

	// result staging, cleared when an item is taken
	always_ff @(posedge clk) begin
		if (in_fire) begin
			stage_q <= '0;
		end else begin
			stage_q <= stage_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (uw.emit && !stall) begin
			ovalid_q <= 1'b1;
		end else if (refs.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// queue status joins the staged references
	always_comb begin
		out_d                = stage_q;
		out_d.queue_ended    = empty;
		out_d.is_paused      = rd_paused;
		out_d.pending_orders = pend_w[PEND_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (uw.emit && !stall) begin
			out_q <= out_d;
		end
	end

	assign refs.valid              = ovalid_q;
	assign refs.distance_ref_valid = out_q.distance_ref_valid;
	assign refs.distance_ref       = out_q.distance_ref;
	assign refs.angle_ref_valid    = out_q.angle_ref_valid;
	assign refs.angle_ref          = out_q.angle_ref;
	assign refs.queue_ended        = out_q.queue_ended;
	assign refs.is_paused          = out_q.is_paused;
	assign refs.insert_status      = out_q.insert_status;
	assign refs.pending_orders     = out_q.pending_orders;

	// pointers only move while a program runs
	a_idle_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == UA_IDLE) |=> ($stable(head_q) && $stable(tail_q)))
		else $error("queue pointers moved while idle");

	// the order memory is never written at the idle step
	a_idle_nowr: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == UA_IDLE) |-> !ram_we)
		else $error("order memory written while idle");

	// a new result only appears after the final microcode step
	a_emit_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(step_q == UA_FIN1))
		else $error("result raised outside the final step");
endmodule

FILE: dv/motion_order_sequencer_unit_tb.sv
// testbench: self-checking bench of the motion order sequencer with its own order queue predictor
`timescale 1ns / 1ps

module motion_order_sequencer_unit_tb;
	import mos_pkg::*;

	// the one function code with no meaning; the block only reports queue status
	localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

	localparam int DEPTH       = DEF_QUEUE_DEPTH;
	localparam int PHASE_ITEMS = 190;   // random items per precision setting
	localparam int LONG_HOLD   = 400;   // receiver hold-off that backs the block up
	localparam int SETTLE      = 12;    // cycles after the last result before a register write
	localparam int STALL_LIMIT = 3000;  // cycles without any transfer before giving up

	// one item of the order channel
	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic signed [DIST_W-1:0]  amount;
		logic signed [DIST_W-1:0]  distance;
		logic signed [ANGLE_W-1:0] angle;
	} order_item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PREC_W-1:0] cfg_data;

	mos_in_if orders();
	mos_out_if refs();

	motion_order_sequencer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.orders(orders),
		.refs(refs)
	);

	// items waiting for the driver, and references the block still owes us
	order_item_t orders_to_send[$];
	result_t awaited_refs[$];

	// predicted order queue: kind, target and snapshot per slot, plus the two pointers
	logic [KIND_W-1:0] q_kind [DEPTH];
	longint q_target [DEPTH];
	longint q_sdist [DEPTH];
	longint q_sangle [DEPTH];
	bit q_started [DEPTH];
	int unsigned q_head;
	int unsigned q_tail;
	logic [PREC_W-1:0] dist_prec;
	logic [PREC_W-1:0] angle_prec;

	int mismatches;
	int gap_left;
	int stall_left;
	int hold_left;
	int hold_req;
	int hold_seen;
	int quiet_cycles;
	bit idle_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint abs_diff(input longint a, input longint b);
		longint d;
		d = a - b;
		return (d < 0) ? -d : d;
	endfunction

	// saturate to a signed field of w bits
	function automatic longint clamp(input longint x, input int w);
		longint top;
		top = (longint'(1) << (w - 1)) - 1;
		if (x > top)
			return top;
		if (x < -top - 1)
			return -top - 1;
		return x;
	endfunction

	function automatic bit queue_full();
		return ((q_tail + 1) % DEPTH) == q_head;
	endfunction

	function automatic bit head_paused();
		return (q_head != q_tail) && (q_kind[q_head] == KIND_PAUSE);
	endfunction

	// one control tick on the current order; fills in the references it issues
	task automatic tick_current(input longint md, input longint ma, inout result_t r);
		int unsigned h;
		longint aim;
		if (q_head == q_tail)
			return;
		h = q_head;
		// first use of an order freezes the position it is measured from
		if (!q_started[h]) begin
			q_sdist[h] = md;
			q_sangle[h] = ma;
			q_started[h] = 1'b1;
		end
		case (q_kind[h])
			KIND_DIST: begin
				aim = q_sdist[h] + q_target[h];
				// completion uses the exact sum, the issued reference the saturated one
				if (abs_diff(aim, md) < longint'(dist_prec)) begin
					q_head = (q_head + 1) % DEPTH;
				end else begin
					r.distance_ref_valid = 1'b1;
					r.distance_ref = DIST_W'(clamp(aim, DIST_W));
				end
			end
			KIND_AABS, KIND_AREL: begin
				aim = q_target[h];
				if (q_kind[h] == KIND_AREL)
					aim += q_sangle[h];
				if (abs_diff(aim, ma) < longint'(angle_prec)) begin
					q_head = (q_head + 1) % DEPTH;
				end else begin
					r.angle_ref_valid = 1'b1;
					r.angle_ref = ANGLE_W'(clamp(aim, ANGLE_W));
				end
			end
			default: begin
				// a pause holds the robot where it stood when the pause began
				r.distance_ref_valid = 1'b1;
				r.distance_ref = DIST_W'(q_sdist[h]);
				r.angle_ref_valid = 1'b1;
				r.angle_ref = ANGLE_W'(q_sangle[h]);
			end
		endcase
	endtask

	// apply one accepted order item and queue the reference it must produce
	task automatic run_order_item(input order_item_t it);
		result_t r;
		logic [STAT_W-1:0] status;
		longint md;
		longint ma;
		int n;
		r = '0;
		status = ST_OK;
		md = longint'(it.distance);
		ma = longint'(it.angle);
		case (it.func)
			FN_TICK: tick_current(md, ma, r);
			FN_DIST, FN_AABS, FN_AREL: begin
				if (queue_full()) begin
					status = ST_DROPPED;
				end else begin
					q_kind[q_tail] = (it.func == FN_DIST) ? KIND_DIST :
						(it.func == FN_AABS) ? KIND_AABS : KIND_AREL;
					q_target[q_tail] = longint'(it.amount);
					q_started[q_tail] = 1'b0;
					q_tail = (q_tail + 1) % DEPTH;
				end
			end
			FN_PAUSE: begin
				// a pause goes in front of the current order; a full queue loses its newest
				if (!head_paused()) begin
					if (queue_full()) begin
						q_tail = (q_tail + DEPTH - 1) % DEPTH;
						status = ST_EVICTED;
					end
					q_head = (q_head + DEPTH - 1) % DEPTH;
					q_kind[q_head] = KIND_PAUSE;
					q_target[q_head] = 0;
					q_started[q_head] = 1'b0;
				end
				tick_current(md, ma, r);
			end
			FN_RESUME: begin
				for (n = 0; n < DEPTH && head_paused(); n++)
					q_head = (q_head + 1) % DEPTH;
			end
			FN_FLUSH: q_head = q_tail;
			default: ;
		endcase
		r.queue_ended = (q_head == q_tail);
		r.is_paused = head_paused();
		r.insert_status = status;
		r.pending_orders = PEND_W'((q_tail + DEPTH - q_head) % DEPTH);
		awaited_refs.push_back(r);
	endtask

	// follows every order transfer and every register write
	always @(posedge clk) begin : order_model
		order_item_t it;
		if (!arst_n) begin
			q_head = 0;
			q_tail = 0;
			dist_prec = DIST_PREC_RST;
			angle_prec = ANGLE_PREC_RST;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_DIST_PREC)
					dist_prec = cfg_data;
				else if (cfg_index == REG_ANGLE_PREC)
					angle_prec = cfg_data;
			end
			if (orders.valid && orders.ready) begin
				it.func = orders.func;
				it.amount = orders.order_amount;
				it.distance = orders.measured_distance;
				it.angle = orders.measured_angle;
				run_order_item(it);
			end
		end
	end

	// ---------------------------------------------------------------- driver

	// the next item goes out once the current one has made its transfer;
	// after some items, while idle_on is set, the channel goes quiet for a random burst
	always @(posedge clk) begin : order_driver
		order_item_t it;
		if (arst_n && (!orders.valid || orders.ready)) begin
			if (gap_left > 0) begin
				gap_left--;
				orders.valid <= 1'b0;
			end else if (orders_to_send.size() > 0) begin
				it = orders_to_send.pop_front();
				orders.valid <= 1'b1;
				orders.func <= it.func;
				orders.order_amount <= it.amount;
				orders.measured_distance <= it.distance;
				orders.measured_angle <= it.angle;
				if (idle_on && $urandom_range(0, 5) == 0)
					gap_left = $urandom_range(1, 11);
			end else begin
				orders.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- receiver side

	// ready: a long hold-off on request, otherwise short random stalls while idle_on is set
	always @(posedge clk) begin : ref_ready
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				refs.ready <= 1'b0;
			end else if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD - 1;
				refs.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				refs.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 10);
				refs.ready <= 1'b0;
			end else begin
				refs.ready <= 1'b1;
			end
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// each result transfer is checked against the oldest awaited reference
	always @(posedge clk) begin : ref_monitor
		result_t want;
		if (arst_n && refs.valid && refs.ready) begin
			if (awaited_refs.size() == 0) begin
				report_mismatch("result transfer with nothing awaited");
			end else begin
				want = awaited_refs.pop_front();
				if (refs.distance_ref_valid !== want.distance_ref_valid)
					report_mismatch($sformatf("distance_ref_valid got %b want %b",
						refs.distance_ref_valid, want.distance_ref_valid));
				if (refs.distance_ref !== want.distance_ref)
					report_mismatch($sformatf("distance_ref got %0d want %0d",
						refs.distance_ref, want.distance_ref));
				if (refs.angle_ref_valid !== want.angle_ref_valid)
					report_mismatch($sformatf("angle_ref_valid got %b want %b",
						refs.angle_ref_valid, want.angle_ref_valid));
				if (refs.angle_ref !== want.angle_ref)
					report_mismatch($sformatf("angle_ref got %0d want %0d",
						refs.angle_ref, want.angle_ref));
				if (refs.queue_ended !== want.queue_ended)
					report_mismatch($sformatf("queue_ended got %b want %b",
						refs.queue_ended, want.queue_ended));
				if (refs.is_paused !== want.is_paused)
					report_mismatch($sformatf("is_paused got %b want %b",
						refs.is_paused, want.is_paused));
				if (refs.insert_status !== want.insert_status)
					report_mismatch($sformatf("insert_status got %0d want %0d",
						refs.insert_status, want.insert_status));
				if (refs.pending_orders !== want.pending_orders)
					report_mismatch($sformatf("pending_orders got %0d want %0d",
						refs.pending_orders, want.pending_orders));
			end
		end
	end

	// a run that stops making transfers is a hung block
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((orders.valid && orders.ready) || (refs.valid && refs.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("no transfer for %0d cycles", STALL_LIMIT);
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic send_order(input logic [FUNC_W-1:0] func, input longint amount,
			input longint distance, input longint angle);
		order_item_t it;
		it.func = func;
		it.amount = DIST_W'(amount);
		it.distance = DIST_W'(distance);
		it.angle = ANGLE_W'(angle);
		orders_to_send.push_back(it);
	endtask

	// mostly small values around zero so that orders really complete,
	// now and then full-width values for saturation and bit coverage
	function automatic order_item_t random_order();
		order_item_t it;
		int r;
		r = $urandom_range(0, 99);
		if (r < 42)
			it.func = FN_TICK;
		else if (r < 56)
			it.func = FN_DIST;
		else if (r < 65)
			it.func = FN_AABS;
		else if (r < 74)
			it.func = FN_AREL;
		else if (r < 82)
			it.func = FN_PAUSE;
		else if (r < 94)
			it.func = FN_RESUME;
		else if (r < 98)
			it.func = FN_FLUSH;
		else
			it.func = FN_UNUSED;
		if ($urandom_range(0, 7) == 0)
			it.amount = $urandom;
		else if (it.func == FN_DIST)
			it.amount = int'($urandom_range(0, 80)) - 40;
		else
			it.amount = int'($urandom_range(0, 800)) - 400;
		if ($urandom_range(0, 7) == 0)
			it.distance = $urandom;
		else
			it.distance = int'($urandom_range(0, 80)) - 40;
		if ($urandom_range(0, 7) == 0)
			it.angle = ANGLE_W'($urandom);
		else
			it.angle = ANGLE_W'(int'($urandom_range(0, 800)) - 400);
		return it;
	endfunction

	// sender holds back until every awaited reference has made its transfer
	task automatic wait_drained();
		@(negedge clk);
		while (orders_to_send.size() > 0 || orders.valid || awaited_refs.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_precisions(input logic [PREC_W-1:0] dp, input logic [PREC_W-1:0] ap);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_DIST_PREC;
		cfg_data <= dp;
		@(posedge clk);
		cfg_index <= REG_ANGLE_PREC;
		cfg_data <= ap;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int phase;
		int i;
		// every input known from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DIST_PREC;
		cfg_data = '0;
		orders.valid = 1'b0;
		orders.func = FN_TICK;
		orders.order_amount = '0;
		orders.measured_distance = '0;
		orders.measured_angle = '0;
		refs.ready = 1'b0;
		mismatches = 0;
		gap_left = 0;
		stall_left = 0;
		hold_left = 0;
		hold_req = 0;
		hold_seen = 0;
		quiet_cycles = 0;
		idle_on = 1'b1;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, reset precisions (16 and 256)
		send_order(FN_TICK, 0, 0, 0);                        // tick on an empty queue
		send_order(FN_UNUSED, -1, -1, -1);                   // unused code, all ones
		send_order(FN_RESUME, 0, 0, 0);
		send_order(FN_FLUSH, 0, 0, 0);
		send_order(FN_DIST, 1600, 0, 0);
		send_order(FN_TICK, 0, 0, 0);                        // issues 1600
		send_order(FN_TICK, 0, 1590, 0);                     // within tolerance: advance, silent
		send_order(FN_AABS, 32'h7fffffff, 0, 0);
		send_order(FN_TICK, 0, 0, -8388608);                 // absolute target saturates high
		send_order(FN_DIST, -2147483648, 0, 0);
		send_order(FN_PAUSE, 0, 123, -77);                   // pause in front, holds snapshot
		send_order(FN_PAUSE, 0, 999, 999);                   // already paused: no insert
		send_order(FN_RESUME, 0, 0, 0);
		send_order(FN_FLUSH, 0, 0, 0);
		send_order(FN_AREL, -2147483648, 0, 0);
		send_order(FN_TICK, 0, -2147483648, -8388608);       // relative angle saturates low
		send_order(FN_FLUSH, 0, 0, 0);
		send_order(FN_DIST, 32'h7fffffff, 0, 0);
		send_order(FN_TICK, 0, 32'h7fffffff, 8388607);       // distance saturates high
		send_order(FN_TICK, 0, -2147483648, 0);              // snapshot kept from first use
		send_order(FN_FLUSH, 0, 0, 0);
		send_order(FN_AREL, 100, 0, 0);
		send_order(FN_TICK, 0, 0, 8388607);                  // exact sum completes, no output
		send_order(FN_TICK, 0, 0, 0);
		wait_drained();

		// random part, one precision setting per phase
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				1: set_precisions('0, '0);                   // nothing ever completes
				2: set_precisions('1, '1);                   // nearly everything completes
				3: set_precisions(PREC_W'($urandom_range(0, 64)),
					PREC_W'($urandom_range(0, 600)));
				4: set_precisions(16'd1, 16'd1);
				5: set_precisions(DIST_PREC_RST, ANGLE_PREC_RST);
				default: ;
			endcase
			// no quiet stretches or random stalls in phase 2 and for the whole last phase
			idle_on = (phase != 2) && (phase != 5);
			// receiver backs off for a long while as the sender keeps offering
			if (phase == 1)
				hold_req++;
			for (i = 0; i < PHASE_ITEMS; i++)
				orders_to_send.push_back(random_order());
			wait_drained();
		end

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: files.f
sv/mos_pkg.sv
sv/mos_in_if.sv
sv/mos_out_if.sv
sv/mos_ram.sv
sv/motion_order_sequencer_unit.sv
dv/motion_order_sequencer_unit_tb.sv
